// ===== rtl/mexp_pkg.sv =====
package mexp_pkg;

  localparam int unsigned DATA_W = 31;
  localparam int unsigned ACC_W = DATA_W + 2;
  localparam int unsigned CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  localparam logic [DATA_W-1:0] MODULUS_RESET = DATA_W'(1000000007);

  localparam int unsigned IN_TDATA_W = 64;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register index taken from paddr[2]
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic op_end;
    logic load_op;
    logic wr_sq;
    logic wr_acc;
    logic shift_e;
    logic load_out;
  } ctrl_t;

endpackage

// ===== rtl/modular_exponentiation_top.sv =====
// modular exponentiation, base ** power mod modulus, right-to-left square-and-multiply
//
// in_*  : stream input, in_tdata = {power, base_value}, transfer when tvalid & tready
// out_* : stream output, out_tdata = residue, one transfer per input item
// cfg_* : register port, register 0 (byte address 0) is the modulus, reset 1000000007
//
// every modular product runs on one bit-serial interleaved multiplier that takes one
// multiplier bit per cycle; the base is first reduced by the same unit, and then one
// multiply per set power bit and one square per power bit below the top bit follow;
// a modulus below two gives 0 and otherwise a zero power gives 1, with no product run
// one item is in work at a time; in_tready is high whenever the unit is idle, so a new
// item can be taken while the previous result still waits in the output register
// if the receiver stalls, the finished result holds the unit until out_tready frees the
// output register
// synchronous active-low reset clears the sequencer and the output valid and reloads
// the modulus register
module modular_exponentiation_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [mexp_pkg::IN_TDATA_W-1:0]       in_tdata,   // [30:0] base_value, [61:31] power
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [mexp_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [30:0] residue
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [mexp_pkg::APB_ADDR_W-1:0]       cfg_paddr,
  input  logic [mexp_pkg::APB_DATA_W-1:0]       cfg_pwdata,
  output logic [mexp_pkg::APB_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int unsigned W = mexp_pkg::DATA_W;
  localparam int unsigned AW = mexp_pkg::ACC_W;

  mexp_pkg::state_t state_r, state_nxt;
  mexp_pkg::ctrl_t  ctrl;

  logic [W-1:0]                modulus_r;
  logic [W-1:0]                e_r;
  logic [W-1:0]                sq_r;
  logic [W-1:0]                acc_r;
  logic [W-1:0]                mx_r;
  logic [W-1:0]                my_r;
  logic [W-1:0]                mr_r;
  logic [mexp_pkg::CNT_W-1:0]  cnt_r;
  logic [W-1:0]                res_r;
  logic                        out_tvalid_r;

  logic [W-1:0]  in_base;
  logic [W-1:0]  in_power;
  logic          mod_small;
  logic          power_zero;
  logic          next_is_mul;
  logic          last_mul;
  logic [AW-1:0] step_sum;
  logic [AW-1:0] mod_x1;
  logic [AW-1:0] mod_x2;
  logic [W-1:0]  step_res;
  logic [W-1:0]  sq_new;
  logic [W-1:0]  acc_new;
  logic [W-1:0]  op_x;
  logic [W-1:0]  op_y;
  logic          cfg_wr;

  assign in_base    = in_tdata[W-1:0];
  assign in_power   = in_tdata[2*W-1:W];
  assign mod_small  = (modulus_r[W-1:1] == '0);
  assign power_zero = (in_power == '0);

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                  (cfg_paddr[2] == mexp_pkg::REG_MODULUS);
  assign cfg_prdata = (cfg_paddr[2] == mexp_pkg::REG_MODULUS) ?
                      mexp_pkg::APB_DATA_W'(modulus_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mexp_pkg::MODULUS_RESET;
    end else if (cfg_wr) begin
      modulus_r <= cfg_pwdata[W-1:0];
    end
  end

  // one multiplier bit per cycle: r = 2r + bit*y, folded back below the modulus
  assign step_sum = {1'b0, mr_r, 1'b0} + (mx_r[W-1] ? AW'(my_r) : '0);
  assign mod_x1   = AW'(modulus_r);
  assign mod_x2   = {1'b0, modulus_r, 1'b0};

  always_comb begin
    priority if (step_sum >= mod_x2) begin
      step_res = W'(step_sum - mod_x2);
    end else if (step_sum >= mod_x1) begin
      step_res = W'(step_sum - mod_x1);
    end else begin
      step_res = W'(step_sum);
    end
  end

  // what follows the op that ends now
  always_comb begin
    unique case (state_r)
      mexp_pkg::ST_RED: next_is_mul = e_r[0];
      mexp_pkg::ST_SQR: next_is_mul = e_r[1];
      default:          next_is_mul = 1'b0;
    endcase
  end

  // skip the square after the top exponent bit
  assign last_mul = (e_r[W-1:1] == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (mod_small || power_zero) ? mexp_pkg::ST_DONE : mexp_pkg::ST_RED;
        end
      end
      mexp_pkg::ST_RED, mexp_pkg::ST_SQR: begin
        if (cnt_r == mexp_pkg::CNT_LAST) begin
          state_nxt = next_is_mul ? mexp_pkg::ST_MUL : mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_MUL: begin
        if (cnt_r == mexp_pkg::CNT_LAST) begin
          state_nxt = last_mul ? mexp_pkg::ST_DONE : mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = mexp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mexp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready       = (state_r == mexp_pkg::ST_IDLE);
    ctrl.accept     = in_tready & in_tvalid;
    ctrl.step       = (state_r == mexp_pkg::ST_RED) || (state_r == mexp_pkg::ST_MUL) ||
                      (state_r == mexp_pkg::ST_SQR);
    ctrl.op_end     = ctrl.step && (cnt_r == mexp_pkg::CNT_LAST);
    ctrl.load_op    = (ctrl.accept && !mod_small && !power_zero) ||
                      (ctrl.op_end && !((state_r == mexp_pkg::ST_MUL) && last_mul));
    ctrl.wr_sq      = ctrl.op_end &&
                      ((state_r == mexp_pkg::ST_RED) || (state_r == mexp_pkg::ST_SQR));
    ctrl.wr_acc     = ctrl.op_end && (state_r == mexp_pkg::ST_MUL);
    ctrl.shift_e    = ctrl.op_end && (state_r == mexp_pkg::ST_SQR);
    ctrl.load_out   = (state_r == mexp_pkg::ST_DONE) && (!out_tvalid_r || out_tready);
  end

  // bypass the product that is written this cycle into the next op's operands
  assign sq_new  = ctrl.wr_sq  ? step_res : sq_r;
  assign acc_new = ctrl.wr_acc ? step_res : acc_r;

  always_comb begin
    if (ctrl.accept) begin
      // base mod m as base * 1
      op_x = in_base;
      op_y = W'(1);
    end else if (next_is_mul) begin
      op_x = acc_new;
      op_y = sq_new;
    end else begin
      op_x = sq_new;
      op_y = sq_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mexp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      e_r   <= in_power;
      acc_r <= mod_small ? '0 : W'(1);
    end else begin
      if (ctrl.shift_e) begin
        e_r <= e_r >> 1;
      end
      if (ctrl.wr_acc) begin
        acc_r <= step_res;
      end
    end
    if (ctrl.wr_sq) begin
      sq_r <= step_res;
    end
    if (ctrl.load_op) begin
      mx_r  <= op_x;
      my_r  <= op_y;
      mr_r  <= '0;
      cnt_r <= '0;
    end else if (ctrl.step) begin
      mx_r  <= mx_r << 1;
      mr_r  <= step_res;
      cnt_r <= cnt_r + 1'b1;
    end
    if (ctrl.load_out) begin
      res_r <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = mexp_pkg::OUT_TDATA_W'(res_r);

  a_op_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_IDLE) && in_tvalid && !mod_small && !power_zero |=>
      (state_r == mexp_pkg::ST_RED) && (cnt_r == '0) && (mr_r == '0))
    else $error("reduction did not start from a cleared multiplier");

  a_exp_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_MUL) || (state_r == mexp_pkg::ST_SQR) |-> (e_r != '0))
    else $error("multiply or square with exhausted exponent");

  a_small_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_IDLE) && in_tvalid && mod_small |=>
      (state_r == mexp_pkg::ST_DONE) && (acc_r == '0))
    else $error("modulus below two did not give zero");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_DONE) && (!out_tvalid_r || out_tready) |=>
      out_tvalid_r && (state_r == mexp_pkg::ST_IDLE))
    else $error("finished result not moved to the output register");

endmodule

// ===== tb/sv/modular_exponentiation_top_tb.sv =====
module modular_exponentiation_top_tb;

  localparam int unsigned STALL_LIMIT = 40000;
  localparam logic [mexp_pkg::APB_ADDR_W-1:0] ADDR_MODULUS = {mexp_pkg::REG_MODULUS, 2'b00};
  localparam logic [mexp_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED =
    {~mexp_pkg::REG_MODULUS, 2'b00};

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [mexp_pkg::IN_TDATA_W-1:0]  in_tdata;   // [30:0] base_value, [61:31] power
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [mexp_pkg::OUT_TDATA_W-1:0] out_tdata;  // [30:0] residue
  logic                             cfg_psel;
  logic                             cfg_penable;
  logic                             cfg_pwrite;
  logic [mexp_pkg::APB_ADDR_W-1:0]  cfg_paddr;
  logic [mexp_pkg::APB_DATA_W-1:0]  cfg_pwdata;
  logic [mexp_pkg::APB_DATA_W-1:0]  cfg_prdata;
  logic                             cfg_pready;

  logic [mexp_pkg::DATA_W-1:0] residue_q[$];
  logic [mexp_pkg::DATA_W-1:0] modulus_cfg;
  logic [mexp_pkg::DATA_W-1:0] want_residue;
  logic                        idle_en;
  int unsigned                 mismatches;
  int unsigned                 quiet_cycles;

  modular_exponentiation_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // right-to-left square-and-multiply, products fit in 62 bits
  function automatic logic [mexp_pkg::DATA_W-1:0] pow_mod(
      input logic [mexp_pkg::DATA_W-1:0] b,
      input logic [mexp_pkg::DATA_W-1:0] p,
      input logic [mexp_pkg::DATA_W-1:0] m);
    logic [63:0] sq;
    logic [63:0] acc;
    logic [63:0] m64;
    logic [mexp_pkg::DATA_W-1:0] e;
    if (m < 2) return '0;
    sq  = 64'(b);
    acc = 64'd1;
    m64 = 64'(m);
    e   = p;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % m64;
      sq = (sq * sq) % m64;
      e  = e >> 1;
    end
    return acc[mexp_pkg::DATA_W-1:0];
  endfunction

  always @(negedge clk) begin
    out_tready <= idle_en ? ($urandom_range(99) >= 26) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (residue_q.size() == 0) begin
        $error("residue: unexpected transfer, actual %0d",
               out_tdata[mexp_pkg::DATA_W-1:0]);
        mismatches++;
      end else begin
        want_residue = residue_q.pop_front();
        if (out_tdata[mexp_pkg::DATA_W-1:0] !== want_residue) begin
          $error("residue: expected %0d, actual %0d", want_residue,
                 out_tdata[mexp_pkg::DATA_W-1:0]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("modular_exponentiation_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pow(input logic [mexp_pkg::DATA_W-1:0] b,
                          input logic [mexp_pkg::DATA_W-1:0] p);
    @(negedge clk);
    while (idle_en && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(mexp_pkg::IN_TDATA_W - 2 * mexp_pkg::DATA_W){1'b0}}, p, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    residue_q.push_back(pow_mod(b, p, modulus_cfg));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [mexp_pkg::APB_ADDR_W-1:0] addr,
                           input logic [mexp_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr[2] == mexp_pkg::REG_MODULUS) modulus_cfg = data[mexp_pkg::DATA_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic cfg_check_modulus();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_MODULUS;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== mexp_pkg::APB_DATA_W'(modulus_cfg)) begin
      $error("modulus: expected %0d, actual %0d", modulus_cfg, cfg_prdata);
      mismatches++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_default_modulus();
    cfg_check_modulus();
    send_pow('0, '0);
    send_pow('0, 31'd5);
    send_pow('1, '0);
    send_pow('1, '1);
    send_pow(31'd1, '1);
    send_pow(31'd2, 31'd10);
    send_pow(31'd2, 31'd30);
    send_pow(modulus_cfg, 31'd3);
    send_pow(modulus_cfg + 31'd5, 31'd7);
    // prime modulus, power m-2 gives the inverse
    send_pow(31'd12345, modulus_cfg - 31'd2);
    drain_results();
  endtask

  task automatic test_modulus_extremes();
    cfg_write(ADDR_MODULUS, 32'd2);
    send_pow('1, '1);
    send_pow(31'd4, 31'd3);
    drain_results();
    // bit 31 lies above the register and is dropped
    cfg_write(ADDR_MODULUS, 32'hffff_ffff);
    cfg_check_modulus();
    send_pow('1, '1);
    send_pow(31'h7fff_fffe, 31'h5555_5555);
    send_pow(31'h1234_5678, '0);
    drain_results();
    // modulus below two gives zero for every item
    cfg_write(ADDR_MODULUS, 32'd1);
    send_pow(31'd3, '0);
    send_pow(31'd3, 31'd9);
    drain_results();
    cfg_write(ADDR_MODULUS, 32'd0);
    send_pow(31'd7, '0);
    send_pow('1, '1);
    drain_results();
    // unmapped register index leaves the modulus alone
    cfg_write(ADDR_MODULUS, 32'd97);
    cfg_write(ADDR_UNMAPPED, 32'd55);
    cfg_check_modulus();
    send_pow(31'd96, 31'd95);
    send_pow(31'd200, 31'd13);
    drain_results();
  endtask

  task automatic test_random_items();
    logic [mexp_pkg::DATA_W-1:0] b;
    logic [mexp_pkg::DATA_W-1:0] p;
    logic [mexp_pkg::APB_DATA_W-1:0] m;
    int unsigned pick;
    for (int phase = 0; phase < 6; phase++) begin
      pick = $urandom_range(99);
      if (phase == 0) m = 32'(mexp_pkg::MODULUS_RESET);
      else if (pick < 25) m = $urandom_range(60, 2);
      else if (pick < 35) m = 32'h7fff_ffff;
      else m = $urandom();
      if (m[mexp_pkg::DATA_W-1:0] < 2) m = 32'd3;
      cfg_write(ADDR_MODULUS, m);
      idle_en = (phase != 2);
      for (int n = 0; n < 45; n++) begin
        pick = $urandom_range(99);
        if (pick < 15) b = 31'($urandom_range(3));
        else if (pick < 30) b = modulus_cfg - 31'($urandom_range(2)) + 31'($urandom_range(2));
        else b = 31'($urandom());
        pick = $urandom_range(99);
        if (pick < 15) p = 31'($urandom_range(1));
        else if (pick < 60) p = 31'($urandom_range(1023));
        else p = 31'($urandom());
        send_pow(b, p);
        // hold off until the block has nothing pending
        if (phase == 3 && n == 24) drain_results();
      end
      drain_results();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    idle_en      = 1'b1;
    mismatches   = 0;
    quiet_cycles = 0;
    modulus_cfg  = mexp_pkg::MODULUS_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_modulus();
    test_modulus_extremes();
    test_random_items();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("modular_exponentiation_top: match");
    end else begin
      $display("modular_exponentiation_top: mismatch");
    end
    $finish;
  end

endmodule
